>>> rtl/lc3s_pkg.sv
// lc3s_pkg: types and constants shared by the lc3 instruction step block
// no dependencies

package lc3s_pkg;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [2:0] TRAP_LINK_REG = 3'd7;
	localparam logic [2:0] NZP_RESET     = 3'b010;

	// item as held in the queue between front and back
	typedef struct packed {
		logic        func;
		logic [15:0] load_addr;
		logic [15:0] load_data;
	} item_t;

	// result item
	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] instr_word;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_addr;
		logic [15:0] mem_value;
		logic [2:0]  cond_codes;
	} result_t;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		logic [2:0] f;
		if (v == 16'd0) begin
			f = 3'b010;
		end else if (v[15]) begin
			f = 3'b100;
		end else begin
			f = 3'b001;
		end
		return f;
	endfunction

endpackage

>>> rtl/lc3s_ram.sv
// lc3s_ram: generic single port word memory with registered read
// depends on nothing

module lc3s_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> rtl/lc3s_front.sv
// lc3s_front: input stage and two entry queue towards the execute sequencer
// depends on lc3s_pkg

module lc3s_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lc3s_pkg::item_t in_item,
	output logic            q_valid,
	input  logic            q_pop,
	output lc3s_pkg::item_t q_item
);

	lc3s_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

>>> rtl/lc3s_back.sv
// lc3s_back: execute sequencer with register file, flags and memory port
// depends on lc3s_pkg and lc3s_ram

module lc3s_back #(
	parameter int MEM_DEPTH = 65536,
	parameter int NUM_REGS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  lc3s_pkg::item_t   q_item,
	output logic              res_valid,
	input  logic              res_ready,
	output lc3s_pkg::result_t res
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int RW = $clog2(NUM_REGS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_DEC   = 3'd2;
	localparam logic [2:0] ST_MEM   = 3'd3;

	logic [2:0]  state_q;
	logic [15:0] pc_q;
	logic [15:0] regs_q [NUM_REGS];
	logic [2:0]  nzp_q;
	logic [15:0] ir_q;
	logic [15:0] ea_q;

	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_addr;
	logic [15:0]       ram_wdata;
	logic [15:0]       ram_rdata;

	logic [3:0]        op;
	logic [RW-1:0]     dr;
	logic [RW-1:0]     sr1;
	logic [RW-1:0]     sr2;
	logic [15:0]       src_a;
	logic [15:0]       src_b;
	logic [15:0]       alu;
	logic [15:0]       off9;
	logic [15:0]       pc_off;

	logic [2:0]        state_d;
	logic [15:0]       pc_d;
	logic [2:0]        nzp_d;
	logic              res_valid_d;
	lc3s_pkg::result_t res_d;
	logic              rf_we;
	logic [RW-1:0]     rf_idx;
	logic [15:0]       rf_wdata;

	assign out_free = !res_valid || res_ready;

	// decode of the fetched instruction on the memory read data
	assign op     = ram_rdata[15:12];
	assign dr     = ram_rdata[9 +: RW];
	assign sr1    = ram_rdata[6 +: RW];
	assign sr2    = ram_rdata[0 +: RW];
	assign src_a  = regs_q[sr1];
	assign src_b  = ram_rdata[5] ? {{11{ram_rdata[4]}}, ram_rdata[4:0]} : regs_q[sr2];
	assign alu    = (op == lc3s_pkg::OP_ADD) ? (src_a + src_b)
		: (op == lc3s_pkg::OP_AND) ? (src_a & src_b) : ~src_a;
	assign off9   = {{7{ram_rdata[8]}}, ram_rdata[8:0]};
	assign pc_off = pc_q + off9;

	// memory port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = pc_q[AW-1:0];
		ram_wdata = q_item.load_data;
		q_pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (!q_item.func) begin
						ram_we   = 1'b1;
						ram_addr = q_item.load_addr[AW-1:0];
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_DEC: begin
				case (op)
					lc3s_pkg::OP_LD: begin
						ram_re   = 1'b1;
						ram_addr = pc_off[AW-1:0];
					end
					lc3s_pkg::OP_ST: begin
						ram_we    = 1'b1;
						ram_addr  = pc_off[AW-1:0];
						ram_wdata = regs_q[dr];
					end
					lc3s_pkg::OP_TRAP: begin
						ram_re   = 1'b1;
						ram_addr = AW'(ram_rdata[7:0]);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	lc3s_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// sequencer next state, architectural updates and result contents
	always_comb begin
		state_d     = state_q;
		pc_d        = pc_q;
		nzp_d       = nzp_q;
		res_valid_d = res_valid && !res_ready;
		res_d       = res;
		rf_we       = 1'b0;
		rf_idx      = dr;
		rf_wdata    = alu;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					if (!q_item.func) begin
						res_valid_d      = 1'b1;
						res_d            = '0;
						res_d.next_pc    = pc_q;
						res_d.cond_codes = nzp_q;
					end else begin
						pc_d    = pc_q + 16'd1;
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_DEC;
			end
			ST_DEC: begin
				res_d            = '0;
				res_d.instr_word = ram_rdata;
				res_d.next_pc    = pc_q;
				res_d.cond_codes = nzp_q;
				res_valid_d      = 1'b1;
				state_d          = ST_IDLE;
				case (op)
					lc3s_pkg::OP_ADD, lc3s_pkg::OP_AND, lc3s_pkg::OP_NOT: begin
						rf_we             = 1'b1;
						nzp_d             = lc3s_pkg::flags_of(alu);
						res_d.reg_written = 1'b1;
						res_d.reg_index   = 3'(dr);
						res_d.reg_value   = alu;
						res_d.cond_codes  = lc3s_pkg::flags_of(alu);
					end
					lc3s_pkg::OP_ST: begin
						res_d.mem_written = 1'b1;
						res_d.mem_addr    = pc_off;
						res_d.mem_value   = regs_q[dr];
					end
					lc3s_pkg::OP_BR: begin
						if ((ram_rdata[11:9] & nzp_q) != 3'd0) begin
							pc_d          = pc_off;
							res_d.next_pc = pc_off;
						end
					end
					lc3s_pkg::OP_JMP: begin
						pc_d          = src_a;
						res_d.next_pc = src_a;
					end
					lc3s_pkg::OP_LD, lc3s_pkg::OP_TRAP: begin
						res_valid_d = 1'b0;
						state_d     = ST_MEM;
					end
					default: begin
					end
				endcase
			end
			ST_MEM: begin
				res_valid_d = 1'b1;
				state_d     = ST_IDLE;
				rf_we       = 1'b1;
				if (ir_q[15:12] == lc3s_pkg::OP_LD) begin
					rf_idx            = ir_q[9 +: RW];
					rf_wdata          = ram_rdata;
					nzp_d             = lc3s_pkg::flags_of(ram_rdata);
					res_d.reg_written = 1'b1;
					res_d.reg_index   = ir_q[11:9];
					res_d.reg_value   = ram_rdata;
					res_d.mem_addr    = ea_q;
					res_d.mem_value   = ram_rdata;
					res_d.cond_codes  = lc3s_pkg::flags_of(ram_rdata);
				end else begin
					rf_idx            = RW'(lc3s_pkg::TRAP_LINK_REG);
					rf_wdata          = pc_q;
					res_d.reg_written = 1'b1;
					res_d.reg_index   = lc3s_pkg::TRAP_LINK_REG;
					res_d.reg_value   = pc_q;
					pc_d              = ram_rdata;
					res_d.next_pc     = ram_rdata;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= 16'd0;
			nzp_q     <= lc3s_pkg::NZP_RESET;
			res_valid <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 16'd0;
			end
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			nzp_q     <= nzp_d;
			res_valid <= res_valid_d;
			if (rf_we) begin
				regs_q[rf_idx] <= rf_wdata;
			end
		end
	end

	// held instruction, effective address and result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DEC) begin
			ir_q <= ram_rdata;
			ea_q <= pc_off;
		end
		res <= res_d;
	end

endmodule

>>> rtl/lc3_instruction_step_top.sv
// lc3_instruction_step_top: top level of the lc3 subset core
// depends on lc3s_pkg, lc3s_front, lc3s_back, lc3s_ram
//
// Each item either loads one memory word (func 0, a write in the back
// sequencer) or runs one instruction (func 1): fetch from the single port
// word memory, then decode and execute, plus a further memory access for
// LD and TRAP. A two entry queue takes items while the sequencer works,
// and a result register holds the finished item until it is taken. Memory
// words are undefined until written; no clearing pass is made.

module lc3_instruction_step_top #(
	parameter int MEM_DEPTH = 65536,
	parameter int NUM_REGS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] load_addr,
	input  logic [15:0] load_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] next_pc,
	output logic [15:0] instr_word,
	output logic        reg_written,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic        mem_written,
	output logic [15:0] mem_addr,
	output logic [15:0] mem_value,
	output logic [2:0]  cond_codes
);

	lc3s_pkg::item_t   in_item;
	lc3s_pkg::item_t   q_item;
	lc3s_pkg::result_t res;
	logic              q_valid;
	logic              q_pop;

	assign in_item.func      = func;
	assign in_item.load_addr = load_addr;
	assign in_item.load_data = load_data;

	// front: accept and queue items
	lc3s_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	// back: execute
	lc3s_back #(.MEM_DEPTH(MEM_DEPTH), .NUM_REGS(NUM_REGS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res      (res)
	);

	assign next_pc     = res.next_pc;
	assign instr_word  = res.instr_word;
	assign reg_written = res.reg_written;
	assign reg_index   = res.reg_index;
	assign reg_value   = res.reg_value;
	assign mem_written = res.mem_written;
	assign mem_addr    = res.mem_addr;
	assign mem_value   = res.mem_value;
	assign cond_codes  = res.cond_codes;

endmodule

>>> rtl/lc3s_checker.sv
// lc3s_checker: port level checks for the lc3 instruction step block
// depends on lc3s_pkg and the lc3_instruction_step_top ports

module lc3s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        reg_written,
	input logic [2:0]  reg_index,
	input logic        mem_written,
	input logic [15:0] instr_word,
	input logic [15:0] next_pc,
	input logic [2:0]  cond_codes
);

	// a stalled result stays valid and keeps its next pc
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result changed while stalled");

	// flags are one hot whenever a result is valid
	a_nzp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(cond_codes))
		else $error("flags not one hot");

	// never both a register and a memory write in a valid result
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_written && mem_written))
		else $error("register and memory write together");

	// trap links through r7
	a_trap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && instr_word[15:12] == lc3s_pkg::OP_TRAP
		|-> reg_written && reg_index == lc3s_pkg::TRAP_LINK_REG)
		else $error("trap link wrong");

endmodule

bind lc3_instruction_step_top lc3s_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.reg_written(reg_written),
	.reg_index  (reg_index),
	.mem_written(mem_written),
	.instr_word (instr_word),
	.next_pc    (next_pc),
	.cond_codes (cond_codes)
);
